[hw/rtl/hfcf_pkg.sv]
package hfcf_pkg;

  // Frame geometry defaults
  localparam int unsigned FRAME_WIDTH_DEF  = 128;
  localparam int unsigned FRAME_HEIGHT_DEF = 64;

  // Palette geometry
  localparam int unsigned PALETTE_LEN = 256;
  localparam int unsigned PAL_QUARTER = PALETTE_LEN >> 2;
  localparam int unsigned PAL_HALF    = PALETTE_LEN >> 1;

  // Field widths
  localparam int unsigned PX_W   = 7;
  localparam int unsigned PY_W   = 6;
  localparam int unsigned HEAT_W = 8;

  // Request kinds
  localparam logic KIND_PLOT    = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  localparam logic [HEAT_W-1:0] DECAY_RESET = 8'd2;

  typedef struct packed {
    logic              kind;
    logic [PX_W-1:0]   plot_x;
    logic [PY_W-1:0]   plot_y;
    logic [HEAT_W-1:0] plot_heat;
  } in_item_t;

  typedef struct packed {
    logic [PX_W-1:0]   cell_x;
    logic [PY_W-1:0]   cell_y;
    logic [HEAT_W-1:0] heat;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              frame_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Fire palette: red ramp, yellow fading to red, then near white
  function automatic rgb_t palette(logic [HEAT_W-1:0] h);
    rgb_t c;
    c = '0;
    if (32'(h) < PAL_QUARTER) begin
      c.red = 8'(10'(h) << 2);
    end else if (32'(h) < PAL_HALF) begin
      c.red   = 8'd255;
      c.green = 8'(10'd255 - (10'(h - 8'(PAL_QUARTER)) << 2));
    end else begin
      // ((h << 2) - 128) >> 2 reduces to h - 32 for h >= 128
      c.red   = 8'd255;
      c.green = 8'd255;
      c.blue  = h - 8'd32;
    end
    return c;
  endfunction

endpackage

[hw/rtl/heat_frame_cooling_filter_top.sv]
// Channel  | valid       | ready       | payload
// ---------+-------------+-------------+-------------------------
// input    | in_valid_i  | in_ready_o  | in_data_i  (in_item_t)
// output   | out_valid_o | out_ready_i | out_data_o (out_item_t)
// config   | cfg_we_i    | (none)      | cfg_wdata_i (decay_step)
//
// An advance reads its upper and right neighbors at the accept edge, the lower one in the
// next cycle (ST_RD2), and writes the cell back in ST_WB; the left neighbor comes from a
// register. A following advance is accepted as the write-back completes. A plot is written
// at its accept edge; after an advance it waits until the write-back has completed.
// After reset a clearing pass writes zero to all FRAME_WIDTH*FRAME_HEIGHT cells, one
// a cycle, with in_ready_o low. A stalled output holds the write-back until taken.
module heat_frame_cooling_filter_top #(
  parameter int unsigned FRAME_WIDTH  = hfcf_pkg::FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = hfcf_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hfcf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hfcf_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i
);

  localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned XW    = $clog2(FRAME_WIDTH);
  localparam int unsigned YW    = $clog2(FRAME_HEIGHT);
  localparam int unsigned HW    = hfcf_pkg::HEAT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RD2  = 3'b010,
    ST_WB   = 3'b100
  } state_e;

  function automatic logic [AW-1:0] addr_of(int unsigned x, int unsigned y);
    return AW'(y * FRAME_WIDTH + x);
  endfunction

  state_e        state_q, state_d;
  logic          clr_active_q;
  logic [AW-1:0] clr_cnt_q;
  logic [XW-1:0] sweep_x_q, sweep_x_d, adv_x;
  logic [YW-1:0] sweep_y_q, sweep_y_d, adv_y;
  logic [HW-1:0] decay_q;
  logic [HW-1:0] left_q, up_q;
  logic          out_valid_q;
  hfcf_pkg::out_item_t out_data_q;

  logic          accept, out_free, complete, plot_ok, plot_left;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, raddr_a, raddr_b;
  logic [HW-1:0] mem_wdata, rdata_a, rdata_b;
  logic [HW+1:0] sum;
  logic [HW-1:0] avg, heat_new;
  hfcf_pkg::rgb_t rgb;

  // Frame store
  hfcf_frame_mem #(
    .DEPTH (DEPTH),
    .DW    (HW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Handshake
  assign out_free   = !out_valid_q || out_ready_i;
  assign complete   = (state_q == ST_WB) && out_free;
  assign in_ready_o = !clr_active_q &&
                      ((state_q == ST_IDLE) ||
                       (complete && (in_data_i.kind == hfcf_pkg::KIND_ADVANCE)));
  assign accept     = in_valid_i && in_ready_o;

  // Plot lands only on interior cells
  assign plot_ok = accept && (in_data_i.kind == hfcf_pkg::KIND_PLOT) &&
                   (in_data_i.plot_x != '0) && (in_data_i.plot_y != '0) &&
                   (32'(in_data_i.plot_x) < FRAME_WIDTH - 1) &&
                   (32'(in_data_i.plot_y) < FRAME_HEIGHT - 1);
  assign plot_left = plot_ok &&
                     (32'(in_data_i.plot_x) + 1 == 32'(sweep_x_q)) &&
                     (32'(in_data_i.plot_y) == 32'(sweep_y_q));

  // Raster step to the next interior cell
  always_comb begin
    adv_x = sweep_x_q + XW'(1);
    adv_y = sweep_y_q;
    if (32'(sweep_x_q) + 1 >= FRAME_WIDTH - 1) begin
      adv_x = XW'(1);
      if (32'(sweep_y_q) + 1 < FRAME_HEIGHT - 1) begin
        adv_y = sweep_y_q + YW'(1);
      end else begin
        adv_y = YW'(1);
      end
    end
  end

  assign sweep_x_d = complete ? adv_x : sweep_x_q;
  assign sweep_y_d = complete ? adv_y : sweep_y_q;

  // Read addresses: upper/right for the position an accepted advance will use,
  // lower of the current cell while it is in flight
  always_comb begin
    if ((state_q == ST_RD2) || ((state_q == ST_WB) && !out_free)) begin
      raddr_a = addr_of(32'(sweep_x_q), 32'(sweep_y_q) + 1);
    end else begin
      raddr_a = addr_of(32'(sweep_x_d), 32'(sweep_y_d) - 1);
    end
    raddr_b = addr_of(32'(sweep_x_d) + 1, 32'(sweep_y_d));
  end

  // Filter arithmetic
  assign sum      = (HW+2)'(left_q) + (HW+2)'(up_q) + (HW+2)'(rdata_b) + (HW+2)'(rdata_a);
  assign avg      = sum[HW+1:2];
  assign heat_new = (avg <= decay_q) ? '0 : (avg - decay_q);
  assign rgb      = hfcf_pkg::palette(heat_new);

  // Write port: clearing pass, write-back, plot
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    priority if (clr_active_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (complete) begin
      mem_we    = 1'b1;
      mem_waddr = addr_of(32'(sweep_x_q), 32'(sweep_y_q));
      mem_wdata = heat_new;
    end else if (plot_ok) begin
      mem_we    = 1'b1;
      mem_waddr = addr_of(32'(in_data_i.plot_x), 32'(in_data_i.plot_y));
      mem_wdata = in_data_i.plot_heat;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.kind == hfcf_pkg::KIND_ADVANCE)) begin
          state_d = ST_RD2;
        end
      end
      ST_RD2: state_d = ST_WB;
      ST_WB: begin
        if (complete) begin
          state_d = accept ? ST_RD2 : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      sweep_x_q    <= XW'(1);
      sweep_y_q    <= YW'(1);
      decay_q      <= hfcf_pkg::DECAY_RESET;
      left_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      sweep_x_q <= sweep_x_d;
      sweep_y_q <= sweep_y_d;
      if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (32'(clr_cnt_q) == DEPTH - 1) begin
          clr_active_q <= 1'b0;
        end
      end
      if (cfg_we_i) begin
        decay_q <= cfg_wdata_i;
      end
      // Left neighbor: last value written there; border column is always zero
      if (complete) begin
        left_q <= (adv_x == XW'(1)) ? '0 : heat_new;
      end else if (plot_left) begin
        left_q <= in_data_i.plot_heat;
      end
      if (complete) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD2) begin
      up_q <= rdata_a;
    end
    if (complete) begin
      out_data_q.cell_x    <= hfcf_pkg::PX_W'(sweep_x_q);
      out_data_q.cell_y    <= hfcf_pkg::PY_W'(sweep_y_q);
      out_data_q.heat      <= heat_new;
      out_data_q.red       <= rgb.red;
      out_data_q.green     <= rgb.green;
      out_data_q.blue      <= rgb.blue;
      out_data_q.frame_end <= (32'(sweep_x_q) >= FRAME_WIDTH - 2) &&
                              (32'(sweep_y_q) >= FRAME_HEIGHT - 2);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Checks
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_active_q |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  a_wb_no_plot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WB) && accept) |-> (in_data_i.kind == hfcf_pkg::KIND_ADVANCE))
    else $error("plot accepted against a write-back");

  a_rd2_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD2) |=> (state_q == ST_WB))
    else $error("second read not followed by write-back");

  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WB))
    else $error("result raised outside write-back");

  a_sweep_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(sweep_x_q) >= 1) && (32'(sweep_x_q) <= FRAME_WIDTH - 2) &&
    (32'(sweep_y_q) >= 1) && (32'(sweep_y_q) <= FRAME_HEIGHT - 2))
    else $error("sweep position left the interior");

endmodule

[hw/rtl/hfcf_frame_mem.sv]
module hfcf_frame_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned DW    = 8,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  output logic [DW-1:0] rdata_a_o,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem_q [DEPTH];

  // One write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

[sim/heat_frame_cooling_filter_tb.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int FW          = hfcf_pkg::FRAME_WIDTH_DEF;
  localparam int FH          = hfcf_pkg::FRAME_HEIGHT_DEF;
  localparam int CELLS       = FW * FH;
  // The clearing pass after reset is quiet on both channels; allow several times its length
  localparam int QUIET_LIMIT = 5 * CELLS;
  localparam int SETTLE      = 8;
  localparam int PHASE_ITEMS = 320;
  localparam int TAIL_ITEMS  = 80;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_e;

  // Fire frame predictor plus queue of expected cell updates
  class hfcf_scoreboard;
    logic [7:0]          frame [CELLS];
    int                  col;
    int                  row;
    int                  decay;
    hfcf_pkg::out_item_t cell_q[$];
    int                  errors;
    int                  advances;
    int                  plots;
    int                  ignored;
    int                  sweeps;
    int                  checked;

    function new();
      foreach (frame[i]) frame[i] = 8'd0;
      col      = 1;
      row      = 1;
      decay    = int'(hfcf_pkg::DECAY_RESET);
      errors   = 0;
      advances = 0;
      plots    = 0;
      ignored  = 0;
      sweeps   = 0;
      checked  = 0;
    endfunction

    function int heat_at(int x, int y);
      return int'(frame[y * FW + x]);
    endfunction

    function void note_request(hfcf_pkg::in_item_t req);
      hfcf_pkg::out_item_t e;
      int                  px, py, sum, avg, h;
      if (req.kind == hfcf_pkg::KIND_PLOT) begin
        px = int'(req.plot_x);
        py = int'(req.plot_y);
        plots++;
        // border cells keep their value
        if (px > 0 && px < FW - 1 && py > 0 && py < FH - 1)
          frame[py * FW + px] = req.plot_heat;
        else
          ignored++;
        return;
      end
      advances++;
      sum = heat_at(col + 1, row) + heat_at(col - 1, row)
          + heat_at(col, row + 1) + heat_at(col, row - 1);
      avg = (sum >> 2) & 255;
      h   = (avg <= decay) ? 0 : avg - decay;
      frame[row * FW + col] = 8'(h);
      e.cell_x    = 7'(col);
      e.cell_y    = 6'(row);
      e.heat      = 8'(h);
      // palette: red ramp, yellow to red, then near white
      if (h < 64) begin
        e.red   = 8'(h * 4);
        e.green = 8'd0;
        e.blue  = 8'd0;
      end else if (h < 128) begin
        e.red   = 8'd255;
        e.green = 8'(255 - 4 * (h - 64));
        e.blue  = 8'd0;
      end else begin
        e.red   = 8'd255;
        e.green = 8'd255;
        e.blue  = 8'(h - 32);
      end
      e.frame_end = (col >= FW - 2) && (row >= FH - 2);
      if (e.frame_end) sweeps++;
      cell_q.push_back(e);
      // raster advance, wrap to (1,1) after the last interior cell
      if (col + 1 < FW - 1) begin
        col = col + 1;
      end else begin
        col = 1;
        row = (row + 1 < FH - 1) ? row + 1 : 1;
      end
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(hfcf_pkg::out_item_t got);
      hfcf_pkg::out_item_t e;
      if (cell_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      e = cell_q.pop_front();
      checked++;
      compare_field("cell_x", int'(e.cell_x), int'(got.cell_x));
      compare_field("cell_y", int'(e.cell_y), int'(got.cell_y));
      compare_field("heat", int'(e.heat), int'(got.heat));
      compare_field("red", int'(e.red), int'(got.red));
      compare_field("green", int'(e.green), int'(got.green));
      compare_field("blue", int'(e.blue), int'(got.blue));
      compare_field("frame_end", int'(e.frame_end), int'(got.frame_end));
    endfunction

    function int pending();
      return cell_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  hfcf_pkg::in_item_t  in_data = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we = 1'b0;
  logic [7:0]          cfg_wdata = 8'd0;
  logic                in_ready_o;
  logic                out_valid_o;
  hfcf_pkg::out_item_t out_data_o;

  hfcf_scoreboard sb;
  idle_mode_e     idle_mode = IDLE_FULL;
  int             quiet_cycles = 0;
  int             decay_writes = 0;

  heat_frame_cooling_filter_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    case (idle_mode)
      IDLE_NONE:   return 0;
      IDLE_SPARSE: return ($urandom_range(0, 5) == 0) ? $urandom_range(0, 18) : 0;
      default:     return $urandom_range(0, 18);
    endcase
  endfunction

  // Monitor: results first, then the request accepted at the same edge
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && out_ready) sb.check_result(out_data_o);
      if (in_valid && in_ready_o) sb.note_request(in_data);
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("heat_frame_cooling_filter_top: mismatch");
      $finish;
    end
  end

  // Result sink with random stalls
  initial begin
    int stall;
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic push_request(hfcf_pkg::in_item_t req, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and wait for every pending cell update, optionally settle after;
  // a clock edge comes first so the monitor has logged the last accepted request
  task automatic drain_results(int settle);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_decay(int value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= 8'(value);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.decay = value;
    decay_writes++;
  endtask

  function automatic hfcf_pkg::in_item_t plot_req(int x, int y, int h);
    hfcf_pkg::in_item_t r;
    r.kind      = hfcf_pkg::KIND_PLOT;
    r.plot_x    = 7'(x);
    r.plot_y    = 6'(y);
    r.plot_heat = 8'(h);
    return r;
  endfunction

  function automatic hfcf_pkg::in_item_t advance_req();
    hfcf_pkg::in_item_t r;
    r      = hfcf_pkg::in_item_t'(22'($urandom));
    r.kind = hfcf_pkg::KIND_ADVANCE;
    return r;
  endfunction

  // Mostly advances and hot plots just ahead of the sweep, some plots anywhere
  function automatic hfcf_pkg::in_item_t random_req(int advance_pct);
    hfcf_pkg::in_item_t r;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < advance_pct) return advance_req();
    if (pick < advance_pct + (100 - advance_pct) * 3 / 4) begin
      return plot_req(sb.col + $urandom_range(0, 4) - 1, sb.row + $urandom_range(0, 1),
                      ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(128, 255));
    end
    r      = hfcf_pkg::in_item_t'(22'($urandom));
    r.kind = hfcf_pkg::KIND_PLOT;
    return r;
  endfunction

  initial begin
    int decay_plan [5];
    sb = new();
    decay_plan = '{0, 255, 1, 128, 2};

    repeat (6) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: border plots ignored, palette bands, low average to zero
    idle_mode = IDLE_FULL;
    push_request(plot_req(0, 0, 255), pick_gap());
    push_request(plot_req(127, 63, 255), pick_gap());
    push_request(plot_req(127, 5, 200), pick_gap());
    push_request(plot_req(5, 63, 200), pick_gap());
    push_request(plot_req(0, 30, 77), pick_gap());
    push_request(plot_req(2, 1, 255), pick_gap());
    push_request(plot_req(1, 2, 255), pick_gap());
    push_request(advance_req(), pick_gap());
    push_request(plot_req(3, 1, 255), pick_gap());
    push_request(plot_req(2, 2, 255), pick_gap());
    push_request(advance_req(), pick_gap());
    push_request(advance_req(), 0);
    push_request(advance_req(), 0);
    push_request(advance_req(), 0);
    // re-plot a cell already filtered in this sweep
    push_request(plot_req(1, 1, 0), pick_gap());
    push_request(plot_req(126, 62, 0), pick_gap());
    push_request(plot_req(126, 1, 128), pick_gap());
    push_request(plot_req(1, 62, 64), pick_gap());
    push_request(plot_req(7, 1, 255), pick_gap());
    push_request(plot_req(6, 2, 9), pick_gap());
    push_request(advance_req(), pick_gap());
    push_request(plot_req(8, 1, 255), 0);
    push_request(plot_req(7, 2, 255), 0);
    push_request(advance_req(), 0);
    drain_results(SETTLE);

    // Random phases, one decay setting each
    for (int p = 0; p < 5; p++) begin
      write_decay((p == 4) ? $urandom_range(0, 255) : decay_plan[p]);
      idle_mode = idle_mode_e'(p % 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == PHASE_ITEMS / 2) drain_results(0);
        push_request(random_req(55), pick_gap());
      end
      drain_results(SETTLE);
    end

    // Advance-heavy tail at zero decay
    write_decay(0);
    idle_mode = IDLE_SPARSE;
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      push_request(random_req(90), pick_gap());
    end
    drain_results(SETTLE);

    $display("covered %0d advances and %0d plots (%0d on the border), %0d full sweeps",
             sb.advances, sb.plots, sb.ignored, sb.sweeps);
    $display("checked %0d cell updates over %0d decay settings, %0d errors",
             sb.checked, decay_writes + 1, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("heat_frame_cooling_filter_top: match");
    end else begin
      $display("heat_frame_cooling_filter_top: mismatch");
    end
    $finish;
  end

endmodule
